>>> rtl/smmq_pkg.sv
// smmq_pkg: shared codes, widths and types for the stack with min/max query unit.
// No dependencies; imported by the interfaces and every module of the block.

package smmq_pkg;

   // Payload widths
   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int KIND_W   = 2;

   // Default stack depth (legal range 1 to 64)
   localparam int STACK_DEPTH_DEFAULT = 16;

   typedef logic [ACTION_W-1:0]       action_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [KIND_W-1:0]         kind_type;

   // Request actions
   localparam action_type ACT_PUSH = 3'd0;
   localparam action_type ACT_POP  = 3'd1;
   localparam action_type ACT_MAX  = 3'd2;
   localparam action_type ACT_MIN  = 3'd3;
   localparam action_type ACT_DUMP = 3'd4;

   // Response kinds
   localparam kind_type KIND_MAX      = 2'd0;
   localparam kind_type KIND_MIN      = 2'd1;
   localparam kind_type KIND_DUMP     = 2'd2;
   localparam kind_type KIND_OVERFLOW = 2'd3;

   // One response transaction payload
   typedef struct packed {
      kind_type  kind;
      value_type result_value;
      logic      last;
   } rsp_type;

endpackage

>>> rtl/smmq_if.sv
// smmq_if: valid/ready channel interfaces for requests and responses.
// Depends on smmq_pkg for the payload types.

interface smmq_req_if
   import smmq_pkg::*;
();
   logic       valid;
   logic       ready;
   action_type action;
   value_type  value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface smmq_rsp_if
   import smmq_pkg::*;
();
   logic      valid;
   logic      ready;
   kind_type  kind;
   value_type result_value;
   logic      last;

   modport source (output valid, output kind, output result_value, output last, input ready);
   modport sink   (input valid, input kind, input result_value, input last, output ready);
endinterface

>>> rtl/stack_with_min_max_query_unit.sv
// stack_with_min_max_query_unit: top level of the bounded stack with min/max query.
// Depends on smmq_pkg, smmq_if, smmq_mem, smmq_ctrl and smmq_outbuf.
//
//   Channel    Direction  Payload                        Transaction
//   req_chan   in         action, value                  valid && ready
//   rsp_chan   out        kind, result_value, last       valid && ready
//
// Push and pop complete on acceptance; a push onto a full stack passes through the overflow state to emit overflow.
// Max, min and dump make one memory read per entry, top to bottom, one at a time as set
// by the single read port of the stack memory, whose read data is registered.
// Reset clears the stack count and the control state; memory contents are not cleared.
// A stalled response channel holds the scan (dump) or the final result; requests wait
// until the current transaction's work is done.

module stack_with_min_max_query_unit
   import smmq_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   smmq_req_if.sink   req_chan,
   smmq_rsp_if.source rsp_chan
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   value_type     wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   value_type     rd_data;
   logic          out_free;
   logic          out_load;
   rsp_type       out_data;

   // Stack storage
   smmq_mem #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Decode and scan sequencer
   smmq_ctrl #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW),
      .CW          (CW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .out_free (out_free),
      .out_load (out_load),
      .out_data (out_data)
   );

   // Response register
   smmq_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (out_data),
      .free      (out_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> rtl/smmq_mem.sv
// smmq_mem: stack storage, one write port and one read port, registered read data.
// Depends on smmq_pkg for the value type.

module smmq_mem
   import smmq_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   parameter int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  value_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output value_type     rd_data
);

   value_type mem_array [STACK_DEPTH];
   value_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/smmq_outbuf.sv
// smmq_outbuf: single-entry output register that drives the response channel.
// Depends on smmq_pkg and smmq_rsp_if.

module smmq_outbuf
   import smmq_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   load,
   input  rsp_type load_data,
   output logic   free,
   smmq_rsp_if.source rsp_chan
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // Slot is free when empty or drained this cycle
   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.kind         = data_ff.kind;
   assign rsp_chan.result_value = data_ff.result_value;
   assign rsp_chan.last         = data_ff.last;

endmodule

>>> rtl/smmq_ctrl.sv
// smmq_ctrl: stack pointer, action decode and the scan sequencer for max, min and dump.
// Depends on smmq_pkg and smmq_req_if; drives smmq_mem and smmq_outbuf.

module smmq_ctrl
   import smmq_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   parameter int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
   parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   smmq_req_if.sink      req_chan,
   // memory side
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output value_type     wr_data,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   input  value_type     rd_data,
   // output register side
   input  logic          out_free,
   output logic          out_load,
   output rsp_type       out_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] left_ff, left_in;      // entries not yet read
   logic [AW-1:0] addr_ff, addr_in;      // next read address
   logic          pend_ff, pend_in;      // read data waiting to be used
   logic          plast_ff, plast_in;    // waiting data is the bottom entry
   logic          first_ff, first_in;    // no entry folded into best yet
   action_type    op_ff, op_in;
   value_type     best_ff, best_in;

   logic          consume;
   logic          better;
   value_type     sel;

   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = req_chan.value;
   assign rd_addr = addr_ff;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // Compare of the new entry against the running best
   always_comb begin
      if (op_ff == ACT_MAX) begin
         better = rd_data > best_ff;
      end else begin
         better = rd_data < best_ff;
      end
      sel = (first_ff || better) ? rd_data : best_ff;
   end

   assign consume = pend_ff && (out_free || (op_ff != ACT_DUMP && !plast_ff));

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      left_in  = left_ff;
      addr_in  = addr_ff;
      pend_in  = pend_ff;
      plast_in = plast_ff;
      first_in = first_ff;
      op_in    = op_ff;
      best_in  = best_ff;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      out_load = 1'b0;
      out_data = '{kind: KIND_OVERFLOW, result_value: '0, last: 1'b1};

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.action)
                  ACT_PUSH: begin
                     if (count_ff == CW'(STACK_DEPTH)) begin
                        state_in = ST_OVF;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_POP: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  ACT_MAX, ACT_MIN, ACT_DUMP: begin
                     if (count_ff != '0) begin
                        state_in = ST_SCAN;
                        op_in    = req_chan.action;
                        left_in  = count_ff;
                        addr_in  = AW'(count_ff - 1'b1);
                        pend_in  = 1'b0;
                        first_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Use the waiting entry
            if (consume) begin
               if (op_ff == ACT_DUMP) begin
                  out_load = 1'b1;
                  out_data = '{kind: KIND_DUMP, result_value: rd_data, last: plast_ff};
               end else begin
                  best_in  = sel;
                  first_in = 1'b0;
                  if (plast_ff) begin
                     out_load = 1'b1;
                     out_data = '{kind: (op_ff == ACT_MAX) ? KIND_MAX : KIND_MIN,
                                  result_value: sel, last: 1'b1};
                  end
               end
            end
            if (consume && plast_ff) begin
               state_in = ST_IDLE;
               pend_in  = 1'b0;
               if (op_ff == ACT_DUMP) begin
                  count_in = '0;
               end
            end else if (left_ff != '0 && (!pend_ff || consume)) begin
               // Issue the next read, top to bottom
               rd_en    = 1'b1;
               pend_in  = 1'b1;
               plast_in = (left_ff == CW'(1));
               left_in  = left_ff - 1'b1;
               addr_in  = addr_ff - 1'b1;
            end else if (consume) begin
               pend_in = 1'b0;
            end
         end

         ST_OVF: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // Scan working registers
   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      addr_ff  <= addr_in;
      plast_ff <= plast_in;
      first_ff <= first_in;
      op_ff    <= op_in;
      best_ff  <= best_in;
   end

endmodule

>>> verif/smmq_stack_checker.sv
// smmq_stack_checker: watches both channels of the stack unit, keeps its own copy of the
// stack, predicts every response in order and compares it field by field.
// Depends on smmq_pkg and the channel interfaces in smmq_if.

module smmq_stack_checker
   import smmq_pkg::*;
#(
   parameter int DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   smmq_req_if  req_tap,
   smmq_rsp_if  rsp_tap,
   output int   mismatch_count,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   value_type entries [DEPTH];
   int        fill_level;
   rsp_type   expected_q [$];

   // Append one predicted response behind the older ones
   function automatic void enqueue_expected(rsp_type r);
      expected_q.insert(expected_q.size(), r);
   endfunction

   // Apply one accepted request to the shadow stack and queue the responses it causes
   function automatic void predict_stack_action(action_type act, value_type val);
      value_type best;
      rsp_type   res;
      case (act)
         ACT_PUSH: begin
            if (fill_level >= DEPTH) begin
               // full: value dropped, one overflow notice
               res.kind         = KIND_OVERFLOW;
               res.result_value = '0;
               res.last         = 1'b1;
               enqueue_expected(res);
            end else begin
               entries[fill_level] = val;
               fill_level++;
            end
         end
         ACT_POP: begin
            if (fill_level > 0) fill_level--;
         end
         ACT_MAX, ACT_MIN: begin
            if (fill_level > 0) begin
               best = entries[fill_level - 1];
               for (int i = fill_level - 2; i >= 0; i--) begin
                  if ((act == ACT_MAX) ? (entries[i] > best) : (entries[i] < best))
                     best = entries[i];
               end
               res.kind         = (act == ACT_MAX) ? KIND_MAX : KIND_MIN;
               res.result_value = best;
               res.last         = 1'b1;
               enqueue_expected(res);
            end
         end
         ACT_DUMP: begin
            // top first, last flag on the bottom entry
            for (int i = fill_level - 1; i >= 0; i--) begin
               res.kind         = KIND_DUMP;
               res.result_value = entries[i];
               res.last         = (i == 0);
               enqueue_expected(res);
            end
            fill_level = 0;
         end
         default: ;  // unused action codes are ignored
      endcase
   endfunction

   // Compare one accepted response with the oldest prediction
   function automatic void check_response(rsp_type got);
      rsp_type want;
      if (expected_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("checker: response with none pending: kind %0d value %0d last %0b",
                     got.kind, got.result_value, got.last);
         return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.result_value !== want.result_value ||
          got.last !== want.last) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("checker: expected kind %0d value %0d last %0b, ",
                     want.kind, want.result_value, want.last,
                     "got kind %0d value %0d last %0b",
                     got.kind, got.result_value, got.last);
      end
   endfunction

   // Sample both channels at the rising edge; responses first, then the new request
   always @(posedge clock) begin
      if (reset) begin
         fill_level = 0;
         expected_q.delete();
      end else begin
         if (rsp_tap.valid && rsp_tap.ready)
            check_response('{kind: rsp_tap.kind, result_value: rsp_tap.result_value,
                             last: rsp_tap.last});
         if (req_tap.valid && req_tap.ready)
            predict_stack_action(req_tap.action, req_tap.value);
      end
      outstanding = expected_q.size();
   end

endmodule

>>> verif/tb.sv
// tb: stimulus and verdict for stack_with_min_max_query_unit.
// Depends on smmq_pkg, smmq_if, the unit itself and smmq_stack_checker.

module tb
   import smmq_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         DEPTH        = STACK_DEPTH_DEFAULT;
   localparam int         RANDOM_ITEMS = 450;
   localparam action_type ACT_UNUSED_LO = ACT_DUMP + 3'd1;
   localparam action_type ACT_UNUSED_HI = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   outstanding;
   int   level_guess;
   int   burst_left;
   int   counted;

   // receiver stall pattern state
   int   rx_mode;
   int   rx_phase_left;
   int   rx_run_left;
   bit   rx_run_high;

   smmq_req_if req_if ();
   smmq_rsp_if rsp_if ();

   stack_with_min_max_query_unit #(.STACK_DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   smmq_stack_checker #(.DEPTH(DEPTH)) stack_check (
      .clock          (clock),
      .reset          (reset),
      .req_tap        (req_if),
      .rsp_tap        (rsp_if),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard limit on run time
   initial begin
      #8_000_000;
      $display("tb: done, errors");
      $finish;
   end

   // Receiver: switches among always ready, coin flips, long stall runs and rare stalls
   initial begin
      rsp_if.ready  = 1'b0;
      rx_phase_left = 0;
      rx_run_left   = 0;
      forever begin
         @(negedge clock);
         if (rx_phase_left == 0) begin
            rx_mode       = $urandom_range(0, 3);
            rx_phase_left = $urandom_range(20, 150);
         end
         rx_phase_left--;
         case (rx_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= $urandom_range(0, 1);
            2: begin
               if (rx_run_left == 0) begin
                  rx_run_high = !rx_run_high;
                  rx_run_left = rx_run_high ? $urandom_range(1, 6) : $urandom_range(1, 20);
               end
               rx_run_left--;
               rsp_if.ready <= rx_run_high;
            end
            default: rsp_if.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // Full-range noise in three of eight picks; the rest are extremes, zero, -1 and small values near zero
   function automatic value_type pick_value();
      case ($urandom_range(0, 7))
         0: return value_type'(32'h7FFF_FFFF);
         1: return value_type'(32'h8000_0000);
         2: return '0;
         3: return '1;
         4: return value_type'(int'($urandom_range(0, 20)) - 10);
         default: return value_type'($urandom);
      endcase
   endfunction

   function automatic action_type pick_action();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return ACT_PUSH;
      if (roll < 60) return ACT_POP;
      if (roll < 72) return ACT_MAX;
      if (roll < 84) return ACT_MIN;
      if (roll < 92) return ACT_DUMP;
      return action_type'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
   endfunction

   // Drive one transaction, wait for acceptance, then maybe insert an idle gap
   task automatic send_request(action_type act, value_type val);
      @(negedge clock);
      req_if.valid  <= 1'b1;
      req_if.action <= act;
      req_if.value  <= val;
      do @(posedge clock); while (!req_if.ready);

      // rough occupancy, only used to steer the sequences
      case (act)
         ACT_PUSH: if (level_guess < DEPTH) level_guess++;
         ACT_POP:  if (level_guess > 0) level_guess--;
         ACT_DUMP: level_guess = 0;
         default: ;
      endcase
      counted++;

      if (burst_left > 0) begin
         burst_left--;
      end else begin
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4)) begin
            @(negedge clock);
            req_if.valid  <= 1'b0;
            req_if.action <= action_type'($urandom);
            req_if.value  <= value_type'($urandom);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      end
   endtask

   initial begin
      req_if.valid  = 1'b0;
      req_if.action = ACT_PUSH;
      req_if.value  = '0;
      level_guess   = 0;
      burst_left    = 0;
      counted       = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: max, min, dump and pop on an empty stack, then the unused codes
      send_request(ACT_MAX, '0);
      send_request(ACT_MIN, '0);
      send_request(ACT_DUMP, '0);
      send_request(ACT_POP, '0);
      for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
         send_request(action_type'(a), value_type'($urandom));

      // Directed: fill with extremes, push past full, query, pop, dump
      send_request(ACT_PUSH, value_type'(32'h7FFF_FFFF));
      send_request(ACT_PUSH, value_type'(32'h8000_0000));
      send_request(ACT_PUSH, '0);
      send_request(ACT_PUSH, '1);
      repeat (DEPTH - 4) send_request(ACT_PUSH, pick_value());
      send_request(ACT_PUSH, pick_value());
      send_request(ACT_MAX, '0);
      send_request(ACT_MIN, '0);
      send_request(ACT_POP, '0);
      send_request(ACT_DUMP, '0);

      // Random sequences
      while (counted < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: begin
               // fill to the top, push past it, query, then empty or trim
               while (level_guess < DEPTH) send_request(ACT_PUSH, pick_value());
               repeat ($urandom_range(1, 3)) send_request(ACT_PUSH, pick_value());
               send_request(ACT_MAX, pick_value());
               send_request(ACT_MIN, pick_value());
               send_request($urandom_range(0, 1) ? ACT_DUMP : ACT_POP, pick_value());
            end
            1: begin
               repeat ($urandom_range(10, 30)) send_request(pick_action(), pick_value());
            end
            2: begin
               // drain past empty, then query the empty stack
               while (level_guess > 0) send_request(ACT_POP, pick_value());
               send_request(ACT_POP, pick_value());
               send_request(ACT_MAX, pick_value());
               send_request(ACT_MIN, pick_value());
               send_request(ACT_DUMP, pick_value());
            end
            default: begin
               // shallow stack with many queries and pops
               repeat ($urandom_range(1, 4)) send_request(ACT_PUSH, pick_value());
               repeat ($urandom_range(4, 10))
                  send_request(action_type'($urandom_range(ACT_POP, ACT_MIN)), pick_value());
            end
         endcase
      end

      // Drain and verdict
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DEPTH + 8) @(negedge clock);
      if (mismatch_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
